/* hdl/hhr_pkg.sv */
// Shared constants and fixed-point helpers for the heading-rate evaluator.
`default_nettype none
package hhr_pkg;

  localparam int unsigned TRIG_LAT = 23;
  localparam int unsigned DIV_LAT  = 32;
  localparam int unsigned NUM_W    = 36;
  localparam int unsigned DEN_W    = 32;
  localparam int unsigned QUO_W    = 31;

  localparam logic signed [31:0] LIM_POS = 32'sh7fff_ffff;
  localparam logic signed [31:0] LIM_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    if (v > 64'(LIM_POS)) return LIM_POS;
    if (v < 64'(LIM_NEG)) return LIM_NEG;
    return v[31:0];
  endfunction

  // shift right rounding half away from zero, then saturate
  function automatic logic signed [31:0] fix_round(input logic signed [63:0] p,
                                                   input int unsigned sh);
    logic [63:0]        m;
    logic [63:0]        r;
    logic signed [63:0] v;
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + (64'd1 << (sh - 1))) >> sh;
    v = p[63] ? -$signed(r) : $signed(r);
    return sat_q(v);
  endfunction

endpackage
`default_nettype wire

/* hdl/hhr_sincos.sv */
// Pipelined sine/cosine of a Q16.16 angle by octant folding and Taylor series.
`default_nettype none
module hhr_sincos import hhr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] angle_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  localparam logic signed [63:0] INV_2PI = 64'sd683565276;
  localparam logic [64:0]        QPI     = 65'd3373259426;

  localparam logic [7:0] SIN_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [7:0] COS_DIV [6] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [63:0] SIN_RCP [6] = '{
    (64'd1 << 40) / 64'd6,  (64'd1 << 40) / 64'd20,  (64'd1 << 40) / 64'd42,
    (64'd1 << 40) / 64'd72, (64'd1 << 40) / 64'd110, (64'd1 << 40) / 64'd156};
  localparam logic [63:0] COS_RCP [6] = '{
    (64'd1 << 40) / 64'd2,  (64'd1 << 40) / 64'd12,  (64'd1 << 40) / 64'd30,
    (64'd1 << 40) / 64'd56, (64'd1 << 40) / 64'd90,  (64'd1 << 40) / 64'd132};

  typedef struct packed {
    logic [2:0]  oct;
    logic [31:0] t2;
    logic [32:0] st;
    logic [32:0] ct;
    logic [33:0] sacc;
    logic [33:0] cacc;
    logic [31:0] sp;
    logic [31:0] cp;
    logic [31:0] sq;
    logic [31:0] cq;
  } sc_t;

  // reciprocal estimate is low by at most one
  function automatic logic [31:0] div_fix(input logic [31:0] pr, input logic [31:0] q0,
                                          input logic [7:0] d);
    logic [31:0] r;
    r = pr - 32'(40'(q0) * 40'(d));
    return (r >= 32'(d)) ? q0 + 32'd1 : q0;
  endfunction

  logic [47:0] ph_q;
  logic [2:0]  oct2_q, oct3_q;
  logic [32:0] fs_q;
  logic [31:0] x_q;
  logic [45:0] fm;
  sc_t         sc_q [19];
  sc_t         sc_d [19];
  logic signed [31:0] sin_q, cos_q;
  logic signed [31:0] sin_c, cos_c;

  always_comb begin
    fm = {1'b0, ph_q[44:0]};
    if (ph_q[45]) fm = (46'd1 << 45) - fm;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= 48'(smul(angle_i, 32'sd0) + 64'(angle_i) * INV_2PI);
      oct2_q <= ph_q[47:45];
      fs_q   <= fm[45:13];
      oct3_q <= oct2_q;
      x_q    <= 32'((65'(fs_q) * QPI) >> 32);
    end
  end

  always_comb begin
    sc_d[0]      = '0;
    sc_d[0].oct  = oct3_q;
    sc_d[0].t2   = 32'((64'(x_q) * 64'(x_q)) >> 32);
    sc_d[0].st   = 33'(x_q);
    sc_d[0].ct   = 33'd1 << 32;
    sc_d[0].sacc = 34'(x_q);
    sc_d[0].cacc = 34'd1 << 32;
  end

  for (genvar j = 0; j < 6; j++) begin : g_term
    // next power product
    always_comb begin
      sc_d[3*j+1]    = sc_q[3*j];
      sc_d[3*j+1].sp = 32'((66'(sc_q[3*j].st) * 66'(sc_q[3*j].t2)) >> 32);
      sc_d[3*j+1].cp = 32'((66'(sc_q[3*j].ct) * 66'(sc_q[3*j].t2)) >> 32);
    end
    // divide by factorial step via reciprocal
    always_comb begin
      sc_d[3*j+2]    = sc_q[3*j+1];
      sc_d[3*j+2].sq = 32'((72'(sc_q[3*j+1].sp) * 72'(SIN_RCP[j][39:0])) >> 40);
      sc_d[3*j+2].cq = 32'((72'(sc_q[3*j+1].cp) * 72'(COS_RCP[j][39:0])) >> 40);
    end
    // correct and accumulate
    always_comb begin
      sc_d[3*j+3]    = sc_q[3*j+2];
      sc_d[3*j+3].st = 33'(div_fix(sc_q[3*j+2].sp, sc_q[3*j+2].sq, SIN_DIV[j]));
      sc_d[3*j+3].ct = 33'(div_fix(sc_q[3*j+2].cp, sc_q[3*j+2].cq, COS_DIV[j]));
      if (j % 2 == 0) begin
        sc_d[3*j+3].sacc = sc_q[3*j+2].sacc - 34'(sc_d[3*j+3].st);
        sc_d[3*j+3].cacc = sc_q[3*j+2].cacc - 34'(sc_d[3*j+3].ct);
      end else begin
        sc_d[3*j+3].sacc = sc_q[3*j+2].sacc + 34'(sc_d[3*j+3].st);
        sc_d[3*j+3].cacc = sc_q[3*j+2].cacc + 34'(sc_d[3*j+3].ct);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 19; i++) sc_q[i] <= sc_d[i];
    end
  end

  // round to Q1.30 and unfold the octant
  always_comb begin
    logic signed [31:0] s30, c30, su, cu;
    s30 = 32'((sc_q[18].sacc + 34'd2) >> 2);
    c30 = 32'((sc_q[18].cacc + 34'd2) >> 2);
    su  = sc_q[18].oct[0] ? c30 : s30;
    cu  = sc_q[18].oct[0] ? s30 : c30;
    case (sc_q[18].oct[2:1])
      2'd0:    begin sin_c = su;  cos_c = cu;  end
      2'd1:    begin sin_c = cu;  cos_c = -su; end
      2'd2:    begin sin_c = -su; cos_c = -cu; end
      default: begin sin_c = -cu; cos_c = su;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_c;
      cos_q <= cos_c;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

/* hdl/hhr_div.sv */
// Pipelined restoring divider: a setup stage, then one quotient bit per stage, quotient below 2^31.
`default_nettype none
module hhr_div import hhr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0]      quo_o
);

  typedef struct packed {
    logic [QUO_W-1:0] dvb;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } dv_t;

  dv_t dv_q [DIV_LAT];
  dv_t dv_d [DIV_LAT];

  // dividend is num << 16; its top bits seed the remainder
  always_comb begin
    dv_d[0]     = '0;
    dv_d[0].dvb = {num_i[QUO_W-17:0], 16'd0};
    dv_d[0].den = den_i;
    dv_d[0].rem = DEN_W'(num_i[NUM_W-1:QUO_W-16]);
  end

  for (genvar i = 1; i < DIV_LAT; i++) begin : g_bit
    always_comb begin
      logic [DEN_W:0] rr;
      logic           ge;
      rr          = {dv_q[i-1].rem, dv_q[i-1].dvb[DIV_LAT-1-i]};
      ge          = rr >= (DEN_W+1)'(dv_q[i-1].den);
      dv_d[i]     = dv_q[i-1];
      dv_d[i].rem = ge ? DEN_W'(rr - (DEN_W+1)'(dv_q[i-1].den)) : DEN_W'(rr);
      dv_d[i].quo = {dv_q[i-1].quo[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DIV_LAT; i++) dv_q[i] <= dv_d[i];
    end
  end

  assign quo_o = dv_q[DIV_LAT-1].quo;

endmodule
`default_nettype wire

/* hdl/herding_heading_rate_eval.sv */
// Heading-rate evaluator top: trig, tangent, partials, numerators, quotients.
// Throughput: one word per cycle while the output word is not held; the whole pipeline advances on one enable.
// The tangent and quotient dividers (32 stages each, in series) and the 23-stage trig set the depth.
// Reset clears only the valid bits; no clearing pass, ready right after reset.
`default_nettype none
module herding_heading_rate_eval import hhr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] force_mag_i,
  input  wire logic signed [31:0] gamma_angle_i,
  input  wire logic signed [31:0] p_angle_i,
  input  wire logic signed [31:0] delta_gain_i,
  input  wire logic signed [31:0] pp_angle_i,
  input  wire logic signed [31:0] p_rate_i,
  input  wire logic signed [31:0] p_accel_i,
  input  wire logic signed [31:0] pp_rate_i,
  input  wire logic signed [31:0] gamma_rate_i,
  input  wire logic signed [31:0] gamma_accel_i,
  input  wire logic signed [31:0] force_rate_i,
  input  wire logic signed [31:0] force_accel_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      heading_rate_o,
  output logic signed [31:0]      heading_accel_o,
  output logic signed [31:0]      partial_p_o,
  output logic signed [31:0]      partial_pp_o,
  output logic signed [31:0]      partial_gamma_o,
  output logic signed [31:0]      partial_force_o,
  output logic                    singular_o
);

  localparam int unsigned NST = TRIG_LAT + 2 * DIV_LAT + 16;

  // Everything a word needs on its way down; unused fields fall away per stage.
  typedef struct packed {
    logic signed [31:0] fm, dg, pr, pac, ppr, gr, gac, fr, fac;
    logic signed [31:0] sp, cp, sg, cg, spp, cpp;
    logic [30:0]        ms, mc;
    logic               tneg, flag;
    logic signed [31:0] tn;
    logic signed [63:0] m_tt, m_spt, m_cgt, m_sgt, m_cpt, m_fc, m_dc, m_pr2, m_gr2, m_pp2;
    logic signed [31:0] tsq, spt, cgt, sgt, cpt, fmcg, dgcpp, pr2, gr2, pp2;
    logic signed [31:0] rcpp, rcg, rsg, rspp;
    logic signed [31:0] sec2, dsum, gsum, hterm, vterm;
    logic signed [63:0] m_a1, m_a2, m_den, m_gt, m_fg2, m_dp2, m_frh, m_fah;
    logic signed [31:0] a1, a2, den, gterm, fg2, dp2, frh, fah;
    logic signed [31:0] pterm;
    logic signed [63:0] m_ptn, m_prp, m_pacp, m_grg, m_gacg, m_fgh, m_dvh;
    logic signed [31:0] ptn, prp, pacp, grg, gacg, fgh, dvh;
    logic signed [31:0] wterm;
    logic signed [63:0] m_prw;
    logic signed [31:0] prw;
    logic signed [36:0] n1, n2;
    logic [35:0]        mag1, mag2;
    logic [31:0]        md;
    logic               dz, neg1, neg2, ovf1, ovf2;
    logic signed [31:0] rate, accel;
  } wk_t;

  logic            adv;
  logic [NST-1:0]  vld_q;
  wk_t             in_w;
  wk_t             dly1_q [TRIG_LAT];
  wk_t             t0_q, t0_d;
  wk_t             dly2_q [DIV_LAT];
  wk_t             m_q [14];
  wk_t             m_d [14];
  wk_t             dly3_q [DIV_LAT];
  wk_t             out_q, out_d;
  logic signed [31:0] sin_p, cos_p, sin_g, cos_g, sin_pp, cos_pp;
  logic [QUO_W-1:0] tan_quo, quo1, quo2;

  // single enable: the pipe moves unless the output word is held
  assign adv        = !vld_q[NST-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  hhr_sincos u_trig_p  (.clk_i, .en_i(adv), .angle_i(p_angle_i),
                        .sin_o(sin_p),  .cos_o(cos_p));
  hhr_sincos u_trig_g  (.clk_i, .en_i(adv), .angle_i(gamma_angle_i),
                        .sin_o(sin_g),  .cos_o(cos_g));
  hhr_sincos u_trig_pp (.clk_i, .en_i(adv), .angle_i(pp_angle_i),
                        .sin_o(sin_pp), .cos_o(cos_pp));

  always_comb begin
    in_w     = '0;
    in_w.fm  = force_mag_i;
    in_w.dg  = delta_gain_i;
    in_w.pr  = p_rate_i;
    in_w.pac = p_accel_i;
    in_w.ppr = pp_rate_i;
    in_w.gr  = gamma_rate_i;
    in_w.gac = gamma_accel_i;
    in_w.fr  = force_rate_i;
    in_w.fac = force_accel_i;
  end

  // tangent setup: magnitudes, sign, overflow test ahead of the divider
  always_comb begin
    t0_d      = dly1_q[TRIG_LAT-1];
    t0_d.sp   = sin_p;
    t0_d.cp   = cos_p;
    t0_d.sg   = sin_g;
    t0_d.cg   = cos_g;
    t0_d.spp  = sin_pp;
    t0_d.cpp  = cos_pp;
    t0_d.ms   = sin_p[31] ? 31'(-sin_p) : 31'(sin_p);
    t0_d.mc   = cos_p[31] ? 31'(-cos_p) : 31'(cos_p);
    t0_d.tneg = (t0_d.mc == '0) ? sin_p[31] : (sin_p[31] != cos_p[31]);
    t0_d.flag = (t0_d.mc == '0) || (48'(t0_d.ms) >= (48'(t0_d.mc) << 15));
  end

  hhr_div u_div_tan (.clk_i, .en_i(adv), .num_i(NUM_W'(t0_q.ms)), .den_i(DEN_W'(t0_q.mc)),
                     .quo_o(tan_quo));

  // tangent, held at full scale on overflow
  always_comb begin
    logic signed [31:0] q;
    m_d[0]    = dly2_q[DIV_LAT-1];
    q         = m_d[0].flag ? LIM_POS : 32'(tan_quo);
    m_d[0].tn = m_d[0].tneg ? -q : q;
  end

  always_comb begin
    m_d[1]       = m_q[0];
    m_d[1].m_tt  = smul(m_q[0].tn,  m_q[0].tn);
    m_d[1].m_spt = smul(m_q[0].spp, m_q[0].tn);
    m_d[1].m_cgt = smul(m_q[0].cg,  m_q[0].tn);
    m_d[1].m_sgt = smul(m_q[0].sg,  m_q[0].tn);
    m_d[1].m_cpt = smul(m_q[0].cpp, m_q[0].tn);
    m_d[1].m_fc  = smul(m_q[0].fm,  m_q[0].cg);
    m_d[1].m_dc  = smul(m_q[0].dg,  m_q[0].cpp);
    m_d[1].m_pr2 = smul(m_q[0].pr,  m_q[0].pr);
    m_d[1].m_gr2 = smul(m_q[0].gr,  m_q[0].gr);
    m_d[1].m_pp2 = smul(m_q[0].ppr, m_q[0].ppr);
  end

  always_comb begin
    m_d[2]       = m_q[1];
    m_d[2].tsq   = fix_round(m_q[1].m_tt, 16);
    m_d[2].spt   = fix_round(m_q[1].m_spt, 30);
    m_d[2].cgt   = fix_round(m_q[1].m_cgt, 30);
    m_d[2].sgt   = fix_round(m_q[1].m_sgt, 30);
    m_d[2].cpt   = fix_round(m_q[1].m_cpt, 30);
    m_d[2].fmcg  = fix_round(m_q[1].m_fc, 30);
    m_d[2].dgcpp = fix_round(m_q[1].m_dc, 30);
    m_d[2].pr2   = fix_round(m_q[1].m_pr2, 16);
    m_d[2].gr2   = fix_round(m_q[1].m_gr2, 16);
    m_d[2].pp2   = fix_round(m_q[1].m_pp2, 16);
    // Q1.30 to Q16.16
    m_d[2].rcpp  = fix_round(64'(m_q[1].cpp), 14);
    m_d[2].rcg   = fix_round(64'(m_q[1].cg), 14);
    m_d[2].rsg   = fix_round(64'(m_q[1].sg), 14);
    m_d[2].rspp  = fix_round(64'(m_q[1].spp), 14);
  end

  always_comb begin
    m_d[3]       = m_q[2];
    m_d[3].sec2  = sat_q(64'(m_q[2].tsq) + 64'(ONE_Q16));
    m_d[3].dsum  = sat_q(64'(m_q[2].rcpp) + 64'(m_q[2].spt));
    m_d[3].gsum  = sat_q(64'(m_q[2].rcg) + 64'(m_q[2].sgt));
    m_d[3].hterm = sat_q(64'(m_q[2].rsg) - 64'(m_q[2].cgt));
    m_d[3].vterm = sat_q(64'(m_q[2].rspp) - 64'(m_q[2].cpt));
  end

  always_comb begin
    m_d[4]       = m_q[3];
    m_d[4].m_a1  = smul(m_q[3].fmcg,  m_q[3].sec2);
    m_d[4].m_a2  = smul(m_q[3].dgcpp, m_q[3].sec2);
    m_d[4].m_den = smul(m_q[3].dg,    m_q[3].dsum);
    m_d[4].m_gt  = smul(m_q[3].fm,    m_q[3].gsum);
    m_d[4].m_fg2 = smul(m_q[3].fm,    m_q[3].gr2);
    m_d[4].m_dp2 = smul(m_q[3].dg,    m_q[3].pp2);
    m_d[4].m_frh = smul(m_q[3].fr,    m_q[3].hterm);
    m_d[4].m_fah = smul(m_q[3].fac,   m_q[3].hterm);
  end

  always_comb begin
    m_d[5]       = m_q[4];
    m_d[5].a1    = fix_round(m_q[4].m_a1, 16);
    m_d[5].a2    = fix_round(m_q[4].m_a2, 16);
    m_d[5].den   = fix_round(m_q[4].m_den, 16);
    m_d[5].gterm = fix_round(m_q[4].m_gt, 16);
    m_d[5].fg2   = fix_round(m_q[4].m_fg2, 16);
    m_d[5].dp2   = fix_round(m_q[4].m_dp2, 16);
    m_d[5].frh   = fix_round(m_q[4].m_frh, 16);
    m_d[5].fah   = fix_round(m_q[4].m_fah, 16);
  end

  always_comb begin
    m_d[6]       = m_q[5];
    m_d[6].pterm = sat_q(64'(m_q[5].a1) + 64'(m_q[5].a2));
  end

  always_comb begin
    m_d[7]        = m_q[6];
    m_d[7].m_ptn  = smul(m_q[6].pterm, m_q[6].tn);
    m_d[7].m_prp  = smul(m_q[6].pr,    m_q[6].pterm);
    m_d[7].m_pacp = smul(m_q[6].pac,   m_q[6].pterm);
    m_d[7].m_grg  = smul(m_q[6].gr,    m_q[6].gterm);
    m_d[7].m_gacg = smul(m_q[6].gac,   m_q[6].gterm);
    m_d[7].m_fgh  = smul(m_q[6].fg2,   m_q[6].hterm);
    m_d[7].m_dvh  = smul(m_q[6].dp2,   m_q[6].vterm);
  end

  always_comb begin
    m_d[8]      = m_q[7];
    m_d[8].ptn  = fix_round(m_q[7].m_ptn, 16);
    m_d[8].prp  = fix_round(m_q[7].m_prp, 16);
    m_d[8].pacp = fix_round(m_q[7].m_pacp, 16);
    m_d[8].grg  = fix_round(m_q[7].m_grg, 16);
    m_d[8].gacg = fix_round(m_q[7].m_gacg, 16);
    m_d[8].fgh  = fix_round(m_q[7].m_fgh, 16);
    m_d[8].dvh  = fix_round(m_q[7].m_dvh, 16);
  end

  always_comb begin
    m_d[9]       = m_q[8];
    m_d[9].wterm = sat_q(64'(m_q[8].ptn) + 64'(m_q[8].ptn));
  end

  always_comb begin
    m_d[10]       = m_q[9];
    m_d[10].m_prw = smul(m_q[9].pr2, m_q[9].wterm);
  end

  always_comb begin
    m_d[11]     = m_q[10];
    m_d[11].prw = fix_round(m_q[10].m_prw, 16);
  end

  // numerators, exact
  always_comb begin
    m_d[12]    = m_q[11];
    m_d[12].n1 = 37'(m_q[11].prp) - 37'(m_q[11].frh) - 37'(m_q[11].grg);
    m_d[12].n2 = 37'(m_q[11].pacp) + 37'(m_q[11].prw) - 37'(m_q[11].fah)
               - 37'(m_q[11].gacg) + 37'(m_q[11].fgh) + 37'(m_q[11].dvh);
  end

  // quotient setup: magnitudes, signs, saturation test
  always_comb begin
    m_d[13]      = m_q[12];
    m_d[13].dz   = (m_q[12].den == '0);
    m_d[13].flag = m_q[12].flag || m_d[13].dz;
    m_d[13].md   = m_q[12].den[31] ? 32'(-m_q[12].den) : 32'(m_q[12].den);
    m_d[13].mag1 = m_q[12].n1[36] ? 36'(-m_q[12].n1) : 36'(m_q[12].n1);
    m_d[13].mag2 = m_q[12].n2[36] ? 36'(-m_q[12].n2) : 36'(m_q[12].n2);
    m_d[13].neg1 = m_q[12].n1[36] != m_q[12].den[31];
    m_d[13].neg2 = m_q[12].n2[36] != m_q[12].den[31];
    m_d[13].ovf1 = 48'(m_d[13].mag1) >= (48'(m_d[13].md) << 15);
    m_d[13].ovf2 = 48'(m_d[13].mag2) >= (48'(m_d[13].md) << 15);
  end

  hhr_div u_div_rate  (.clk_i, .en_i(adv), .num_i(m_q[13].mag1), .den_i(m_q[13].md),
                       .quo_o(quo1));
  hhr_div u_div_accel (.clk_i, .en_i(adv), .num_i(m_q[13].mag2), .den_i(m_q[13].md),
                       .quo_o(quo2));

  always_comb begin
    logic signed [31:0] q1, q2;
    out_d = dly3_q[DIV_LAT-1];
    q1    = 32'(quo1);
    q2    = 32'(quo2);
    if (out_d.dz) begin
      out_d.rate  = '0;
      out_d.accel = '0;
    end else begin
      out_d.rate  = out_d.ovf1 ? (out_d.neg1 ? LIM_NEG : LIM_POS) : (out_d.neg1 ? -q1 : q1);
      out_d.accel = out_d.ovf2 ? (out_d.neg2 ? LIM_NEG : LIM_POS) : (out_d.neg2 ? -q2 : q2);
    end
    out_d.pterm = sat_q(-64'(out_d.pterm));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly1_q[0] <= in_w;
      for (int i = 1; i < TRIG_LAT; i++) dly1_q[i] <= dly1_q[i-1];
      t0_q      <= t0_d;
      dly2_q[0] <= t0_q;
      for (int i = 1; i < DIV_LAT; i++) dly2_q[i] <= dly2_q[i-1];
      for (int i = 0; i < 14; i++) m_q[i] <= m_d[i];
      dly3_q[0] <= m_q[13];
      for (int i = 1; i < DIV_LAT; i++) dly3_q[i] <= dly3_q[i-1];
      out_q     <= out_d;
    end
  end

  assign out_valid_o     = vld_q[NST-1];
  assign heading_rate_o  = out_q.rate;
  assign heading_accel_o = out_q.accel;
  assign partial_p_o     = out_q.pterm;
  assign partial_pp_o    = out_q.den;
  assign partial_gamma_o = out_q.gterm;
  assign partial_force_o = out_q.hterm;
  assign singular_o      = out_q.flag;

`ifndef SYNTH
  a_zero_den_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (partial_pp_o == 0) |-> singular_o)
    else $error("zero denominator without singular flag");

  a_zero_den_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (partial_pp_o == 0) |-> (heading_rate_o == 0) && (heading_accel_o == 0))
    else $error("nonzero heading derivative with zero denominator");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output stage free");

  a_pipe_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && in_valid_i |=> vld_q[0])
    else $error("accepted word lost at pipe entry");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking bench for herding_heading_rate_eval: predicted words vs. DUT output.
`default_nettype none
module tb;

  // one input word, one field per port
  typedef struct packed {
    logic signed [31:0] force_mag;
    logic signed [31:0] gamma_angle;
    logic signed [31:0] p_angle;
    logic signed [31:0] delta_gain;
    logic signed [31:0] pp_angle;
    logic signed [31:0] p_rate;
    logic signed [31:0] p_accel;
    logic signed [31:0] pp_rate;
    logic signed [31:0] gamma_rate;
    logic signed [31:0] gamma_accel;
    logic signed [31:0] force_rate;
    logic signed [31:0] force_accel;
  } drive_t;

  // one output word
  typedef struct packed {
    logic signed [31:0] heading_rate;
    logic signed [31:0] heading_accel;
    logic signed [31:0] partial_p;
    logic signed [31:0] partial_pp;
    logic signed [31:0] partial_gamma;
    logic signed [31:0] partial_force;
    logic               singular;
  } heading_t;

  // random value shapes
  typedef enum int {
    VAL_WIDE,   // any 32-bit pattern
    VAL_MID,    // about +-256.0
    VAL_ANGLE,  // about +-8 rad
    VAL_TINY    // about +-2.0
  } val_shape_e;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint Q16_ONE = 64'sd65536;
  localparam longint unsigned INV_TURN = 64'd683565276;   // 1/(2 pi), Q0.32
  localparam longint unsigned EIGHTH_PI = 64'd3373259426; // pi/4, Q0.32
  localparam int HALF_PI_Q16 = 102944;
  localparam int DRAIN_CYCLES = 140;  // pipeline depth is 103

  logic clk = 1'b0;
  logic rst_ni;
  logic in_valid;
  logic out_stall;
  drive_t in_word;
  logic in_stall_o;
  logic out_valid_o;
  heading_t dut_word;

  heading_t pending_headings[$];
  int  mismatches = 0;
  int  words_sent = 0;
  int  words_seen = 0;
  int  singular_seen = 0;
  bit  idle_en = 1'b0;
  int  stall_hold;

  initial begin
    forever #5 clk = ~clk;
  end

  herding_heading_rate_eval uut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .force_mag_i    (in_word.force_mag),
    .gamma_angle_i  (in_word.gamma_angle),
    .p_angle_i      (in_word.p_angle),
    .delta_gain_i   (in_word.delta_gain),
    .pp_angle_i     (in_word.pp_angle),
    .p_rate_i       (in_word.p_rate),
    .p_accel_i      (in_word.p_accel),
    .pp_rate_i      (in_word.pp_rate),
    .gamma_rate_i   (in_word.gamma_rate),
    .gamma_accel_i  (in_word.gamma_accel),
    .force_rate_i   (in_word.force_rate),
    .force_accel_i  (in_word.force_accel),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .heading_rate_o (dut_word.heading_rate),
    .heading_accel_o(dut_word.heading_accel),
    .partial_p_o    (dut_word.partial_p),
    .partial_pp_o   (dut_word.partial_pp),
    .partial_gamma_o(dut_word.partial_gamma),
    .partial_force_o(dut_word.partial_force),
    .singular_o     (dut_word.singular)
  );

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point heading math, all in 64-bit integers
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // product shifted right by sh, rounded half away from zero, saturated
  function automatic longint mul_round(input longint a, input longint b, input int sh);
    longint prod;
    longint unsigned mag;
    longint unsigned rnd;
    prod = a * b;
    mag = (prod < 0) ? longint'(-prod) : prod;
    rnd = (mag + (64'd1 << (sh - 1))) >> sh;
    return clamp32((prod < 0) ? -longint'(rnd) : longint'(rnd));
  endfunction

  // (|num| << 16) / |den|, truncated, signed, saturated
  function automatic longint div_q16(input longint num, input longint den);
    longint unsigned mn;
    longint unsigned md;
    longint unsigned q;
    mn = (num < 0) ? longint'(-num) : num;
    md = (den < 0) ? longint'(-den) : den;
    if (md == 0) return 0;
    q = (mn << 16) / md;
    if (q > 64'd2147483648) q = 64'd2147483648;
    if ((num < 0) != (den < 0)) return clamp32(-longint'(q));
    return clamp32(longint'(q));
  endfunction

  // sin/cos of a Q16.16 angle, Q1.30; Taylor series on one octant
  function automatic void trig_q30(input longint ang, output longint sn, output longint cs);
    longint unsigned phase;
    longint unsigned frac;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned c;
    longint unsigned su;
    longint unsigned cu;
    int oct;
    phase = longint'(ang * longint'(INV_TURN)) & 64'hFFFF_FFFF_FFFF;
    oct = int'(phase >> 45);
    frac = phase & 64'h1FFF_FFFF_FFFF;
    if (oct[0]) frac = (64'd1 << 45) - frac;  // mirror odd octants
    x = ((frac >> 13) * EIGHTH_PI) >> 32;
    x2 = (x * x) >> 32;
    s = x;
    term = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 32) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - term;
      else s = s + term;
    end
    c = 64'd1 << 32;
    term = c;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 32) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) c = c - term;
      else c = c + term;
    end
    s = (s + 2) >> 2;
    c = (c + 2) >> 2;
    if (oct[0]) begin
      su = c;
      cu = s;
    end else begin
      su = s;
      cu = c;
    end
    case (oct >> 1)
      0: begin
        sn = su;
        cs = cu;
      end
      1: begin
        sn = cu;
        cs = -longint'(su);
      end
      2: begin
        sn = -longint'(su);
        cs = -longint'(cu);
      end
      default: begin
        sn = -longint'(cu);
        cs = su;
      end
    endcase
  endfunction

  function automatic heading_t predict_heading(input drive_t w);
    longint fm, dg, pr, pac, ppr, gr, gac, fr, fac;
    longint sp, cp, sg, cg, spp, cpp;
    longint tn, sec2, pterm, den, gterm, hterm, vterm, wterm, n1, n2;
    longint unsigned ms, mc, q;
    bit neg;
    bit flag;
    heading_t r;
    fm = longint'(w.force_mag);
    dg = longint'(w.delta_gain);
    pr = longint'(w.p_rate);
    pac = longint'(w.p_accel);
    ppr = longint'(w.pp_rate);
    gr = longint'(w.gamma_rate);
    gac = longint'(w.gamma_accel);
    fr = longint'(w.force_rate);
    fac = longint'(w.force_accel);
    flag = 1'b0;
    trig_q30(longint'(w.p_angle), sp, cp);
    trig_q30(longint'(w.gamma_angle), sg, cg);
    trig_q30(longint'(w.pp_angle), spp, cpp);

    // tan(p), held at full scale when cos vanishes or the quotient overflows
    ms = (sp < 0) ? longint'(-sp) : sp;
    mc = (cp < 0) ? longint'(-cp) : cp;
    neg = (sp < 0) != (cp < 0);
    if (mc == 0) begin
      q = SAT_HI;
      flag = 1'b1;
      neg = (sp < 0);
    end else begin
      q = (ms << 16) / mc;
      if (q > SAT_HI) begin
        q = SAT_HI;
        flag = 1'b1;
      end
    end
    tn = neg ? -longint'(q) : longint'(q);

    sec2 = clamp32(mul_round(tn, tn, 16) + Q16_ONE);
    pterm = clamp32(mul_round(mul_round(fm, cg, 30), sec2, 16)
                  + mul_round(mul_round(dg, cpp, 30), sec2, 16));
    den = mul_round(dg, clamp32(mul_round(cpp, 1, 14) + mul_round(spp, tn, 30)), 16);
    gterm = mul_round(fm, clamp32(mul_round(cg, 1, 14) + mul_round(sg, tn, 30)), 16);
    hterm = clamp32(mul_round(sg, 1, 14) - mul_round(cg, tn, 30));
    vterm = clamp32(mul_round(spp, 1, 14) - mul_round(cpp, tn, 30));
    wterm = clamp32(2 * mul_round(pterm, tn, 16));

    // numerators are exact sums of saturated products
    n1 = mul_round(pr, pterm, 16) - mul_round(fr, hterm, 16) - mul_round(gr, gterm, 16);
    n2 = mul_round(pac, pterm, 16)
       + mul_round(mul_round(pr, pr, 16), wterm, 16)
       - mul_round(fac, hterm, 16)
       - mul_round(gac, gterm, 16)
       + mul_round(mul_round(fm, mul_round(gr, gr, 16), 16), hterm, 16)
       + mul_round(mul_round(dg, mul_round(ppr, ppr, 16), 16), vterm, 16);

    r.heading_rate = '0;
    r.heading_accel = '0;
    if (den == 0) flag = 1'b1;
    else begin
      r.heading_rate = 32'(div_q16(n1, den));
      r.heading_accel = 32'(div_q16(n2, den));
    end
    r.partial_p = 32'(clamp32(-pterm));
    r.partial_pp = 32'(den);
    r.partial_gamma = 32'(gterm);
    r.partial_force = 32'(hterm);
    r.singular = flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one word per call, optional idle burst first
  // ---------------------------------------------------------------------------
  task automatic send_word(input drive_t w);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    // accepted at this edge
    pending_headings.push_back(predict_heading(w));
    words_sent++;
  endtask

  function automatic logic signed [31:0] rand_val(input val_shape_e shape);
    case (shape)
      VAL_MID:   return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      VAL_ANGLE: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      VAL_TINY:  return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default:   return $urandom;
    endcase
  endfunction

  function automatic drive_t rand_word(input val_shape_e mag_shape);
    drive_t w;
    w.force_mag = rand_val(mag_shape);
    w.gamma_angle = rand_val(VAL_ANGLE);
    w.p_angle = rand_val(VAL_ANGLE);
    w.delta_gain = rand_val(mag_shape);
    w.pp_angle = rand_val(VAL_ANGLE);
    w.p_rate = rand_val(mag_shape);
    w.p_accel = rand_val(mag_shape);
    w.pp_rate = rand_val(mag_shape);
    w.gamma_rate = rand_val(mag_shape);
    w.gamma_accel = rand_val(mag_shape);
    w.force_rate = rand_val(mag_shape);
    w.force_accel = rand_val(mag_shape);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // field extremes, tan overflow at +-pi/2, zero gain, saturating rates
  task automatic test_directed();
    drive_t w;
    w = '0;
    send_word(w);                      // all zero: zero denominator
    w = {12{32'sh7fff_ffff}};
    send_word(w);
    w = {12{32'sh8000_0000}};
    send_word(w);
    w = {12{32'sh0001_0000}};
    send_word(w);
    w = {12{32'shffff_0000}};
    send_word(w);
    for (int i = 0; i < 8; i++) begin
      w = rand_word(VAL_TINY);
      w.p_angle = (i < 4) ? HALF_PI_Q16 - 2 + i : -HALF_PI_Q16 - 6 + i;
      send_word(w);                    // near-vertical p
    end
    w = rand_word(VAL_TINY);
    w.delta_gain = 0;                  // gain zero: denominator zero
    send_word(w);
    w = rand_word(VAL_TINY);
    w.p_angle = 0;
    w.pp_angle = 3 * HALF_PI_Q16;      // cos(pp) ~ 0 with tan(p) = 0
    send_word(w);
    w = rand_word(VAL_WIDE);
    w.p_angle = 0;
    send_word(w);                      // saturating products
    for (int i = 0; i < 6; i++) begin
      w = rand_word(VAL_TINY);
      w.gamma_angle = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
      w.pp_angle = (i % 3 == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      w.p_angle = (i < 3) ? 32'sh0000_c90f : -32'sh0000_c90f; // +-pi/4
      send_word(w);
    end
  endtask

  // arbitrary bit patterns on every field but the three angles
  task automatic test_random_wide(input int n);
    repeat (n) send_word(rand_word(VAL_WIDE));
  endtask

  // plausible magnitudes where the quotients stay in range
  task automatic test_random_physical(input int n);
    repeat (n) send_word(rand_word($urandom_range(0, 1) ? VAL_MID : VAL_TINY));
  endtask

  // singular neighborhood: p near +-pi/2 and zero gain
  task automatic test_singular(input int n);
    drive_t w;
    repeat (n) begin
      w = rand_word(VAL_TINY);
      case ($urandom_range(0, 2))
        0: w.p_angle = HALF_PI_Q16 + $signed($urandom_range(0, 40)) - 20;
        1: w.p_angle = -HALF_PI_Q16 + $signed($urandom_range(0, 40)) - 20;
        default: w.delta_gain = 0;
      endcase
      send_word(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, counted down in clock cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_hold <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // compare each accepted output word with the oldest prediction
  always @(posedge clk) begin
    heading_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_headings.size() == 0) begin
        mismatches++;
        $display("%0t: output word with none expected, expected none actual %h",
                 $time, dut_word);
      end else begin
        want = pending_headings.pop_front();
        words_seen++;
        if (dut_word.singular) singular_seen++;
        check_field("heading_rate", longint'(want.heading_rate),
                    longint'(dut_word.heading_rate));
        check_field("heading_accel", longint'(want.heading_accel),
                    longint'(dut_word.heading_accel));
        check_field("partial_p", longint'(want.partial_p), longint'(dut_word.partial_p));
        check_field("partial_pp", longint'(want.partial_pp), longint'(dut_word.partial_pp));
        check_field("partial_gamma", longint'(want.partial_gamma),
                    longint'(dut_word.partial_gamma));
        check_field("partial_force", longint'(want.partial_force),
                    longint'(dut_word.partial_force));
        check_field("singular", longint'(want.singular), longint'(dut_word.singular));
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    idle_en = 1'b1;
    test_directed();
    test_random_wide(350);
    test_random_physical(450);
    test_singular(150);
    idle_en = 1'b0;                    // back-to-back to the end
    test_random_physical(180);
    in_valid <= 1'b0;

    while (pending_headings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d words sent, %0d checked, %0d flagged singular", words_sent,
             words_seen, singular_seen);
    $display("tb: covered field extremes, tan overflow, zero gain, saturation, stalls");
    if (mismatches == 0 && pending_headings.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
